[hw/rtl/tcsm_pkg.sv]
// Shared types and constants for the TCP connection state machine unit.
// Used by tcsm_cfg_regs, tcsm_core and tcp_connection_state_machine_unit.
package tcsm_pkg;

    // receive buffer size in bytes (64 .. 4096)
    localparam int RX_BUFFER_BYTES = 4096;
    localparam int FILL_W = $clog2(RX_BUFFER_BYTES + 1);
    localparam int SUM_W = ((FILL_W > 16) ? FILL_W : 16) + 1;

    // segment flag masks
    localparam logic [5:0] F_FIN = 6'h01;
    localparam logic [5:0] F_SYN = 6'h02;
    localparam logic [5:0] F_RST = 6'h04;
    localparam logic [5:0] F_PSH = 6'h08;
    localparam logic [5:0] F_ACK = 6'h10;

    // register reset values
    localparam logic [15:0] LOCAL_PORT_RST = 16'd0;
    localparam logic [31:0] INITIAL_SEQ_RST = 32'd0;
    localparam logic [15:0] RECEIVE_WINDOW_RST = 16'd4096;

    typedef enum logic [1:0] {
        KIND_SEGMENT = 2'd0,
        KIND_SEND    = 2'd1,
        KIND_CLOSE   = 2'd2,
        KIND_LISTEN  = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        REG_LOCAL_PORT     = 2'd0,
        REG_INITIAL_SEQ    = 2'd1,
        REG_RECEIVE_WINDOW = 2'd2
    } t_reg_idx;

    typedef struct packed {
        logic [15:0] our_port;
        logic [31:0] initial_seq;
        logic [15:0] receive_window;
    } t_cfg;

    typedef struct packed {
        logic [1:0]  kind;
        logic [5:0]  in_flags;
        logic [31:0] in_seq;
        logic [31:0] in_ack;
        logic [15:0] peer_port;
        logic [15:0] length;
    } t_item;

    typedef struct packed {
        logic        send_segment;
        logic [5:0]  out_flags;
        logic [31:0] out_seq;
        logic [31:0] out_ack;
        logic [15:0] out_src_port;
        logic [15:0] out_dst_port;
        logic [15:0] out_window;
        logic [15:0] out_data_len;
        logic        data_accepted;
        logic        status;
        logic [3:0]  conn_state;
    } t_result;

endpackage

[hw/rtl/tcsm_cfg_regs.sv]
// APB-style configuration registers: local port, initial sequence, receive window.
// Depends on tcsm_pkg.
module tcsm_cfg_regs (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    output tcsm_pkg::t_cfg     o_cfg
);

    logic [15:0]        r_our_port;
    logic [31:0]        r_initial_seq;
    logic [15:0]        r_receive_window;
    logic               wr_en;
    tcsm_pkg::t_reg_idx reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = tcsm_pkg::t_reg_idx'(paddr[3:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_our_port       <= tcsm_pkg::LOCAL_PORT_RST;
            r_initial_seq    <= tcsm_pkg::INITIAL_SEQ_RST;
            r_receive_window <= tcsm_pkg::RECEIVE_WINDOW_RST;
        end else if (wr_en) begin
            case (reg_idx)
                tcsm_pkg::REG_LOCAL_PORT:     r_our_port       <= pwdata[15:0];
                tcsm_pkg::REG_INITIAL_SEQ:    r_initial_seq    <= pwdata;
                tcsm_pkg::REG_RECEIVE_WINDOW: r_receive_window <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            tcsm_pkg::REG_LOCAL_PORT:     prdata = {16'd0, r_our_port};
            tcsm_pkg::REG_INITIAL_SEQ:    prdata = r_initial_seq;
            tcsm_pkg::REG_RECEIVE_WINDOW: prdata = {16'd0, r_receive_window};
            default:                      prdata = 32'd0;
        endcase
    end

    assign o_cfg.our_port       = r_our_port;
    assign o_cfg.initial_seq    = r_initial_seq;
    assign o_cfg.receive_window = r_receive_window;

endmodule

[hw/rtl/tcsm_core.sv]
// Connection state and sequence registers with the per-event next-state logic.
// Depends on tcsm_pkg. Result is combinational; the caller registers it.
module tcsm_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_fire,
    input  tcsm_pkg::t_item     i_item,
    input  tcsm_pkg::t_cfg      i_cfg,
    output tcsm_pkg::t_result   o_res
);

    typedef enum logic [3:0] {
        ST_CLOSED    = 4'd0,
        ST_LISTEN    = 4'd1,
        ST_SYN_SENT  = 4'd2,
        ST_SYN_RCVD  = 4'd3,
        ST_ESTAB     = 4'd4,
        ST_FINWAIT1  = 4'd5,
        ST_FINWAIT2  = 4'd6,
        ST_CLOSEWAIT = 4'd7,
        ST_CLOSING   = 4'd8,
        ST_LASTACK   = 4'd9,
        ST_TIMEWAIT  = 4'd10
    } t_state;

    localparam int FW = tcsm_pkg::FILL_W;
    localparam int SW = tcsm_pkg::SUM_W;

    t_state                  r_state, n_state;
    logic [15:0]             r_peer_port, n_peer_port;
    logic [31:0]             r_rcv_nxt, n_rcv_nxt;
    logic [31:0]             r_snd_una, n_snd_una;
    logic [31:0]             r_snd_nxt, n_snd_nxt;
    logic [FW-1:0]           r_rcv_fill, n_rcv_fill;

    tcsm_pkg::t_kind         kind;
    logic                    has_ack, has_fin, has_syn, has_rst;
    logic [31:0]             ack_diff;
    logic                    una_adv, ack_eq_nxt, seq_match, len_nz, fits;
    logic [SW-1:0]           fill_sum;
    logic                    est_accept, est_fin, est_need;
    logic [31:0]             rcv_est, rcv_plus1;
    logic                    ack_due;
    t_state                  fw1_mid;

    assign kind      = tcsm_pkg::t_kind'(i_item.kind);
    assign has_ack   = (i_item.in_flags & tcsm_pkg::F_ACK) != 6'd0;
    assign has_fin   = (i_item.in_flags & tcsm_pkg::F_FIN) != 6'd0;
    assign has_syn   = (i_item.in_flags & tcsm_pkg::F_SYN) != 6'd0;
    assign has_rst   = (i_item.in_flags & tcsm_pkg::F_RST) != 6'd0;

    // serial (mod 2^32) "ack is after snd_una"
    assign ack_diff  = i_item.in_ack - r_snd_una;
    assign una_adv   = has_ack && (ack_diff != 32'd0) && !ack_diff[31];
    assign ack_eq_nxt = has_ack && (i_item.in_ack == r_snd_nxt);
    assign seq_match = i_item.in_seq == r_rcv_nxt;
    assign len_nz    = i_item.length != 16'd0;
    assign fill_sum  = SW'(r_rcv_fill) + SW'(i_item.length);
    assign fits      = fill_sum <= SW'(tcsm_pkg::RX_BUFFER_BYTES);

    // established: in-order data taken if it fits; FIN taken unless data was dropped
    assign est_accept = seq_match && len_nz && fits;
    assign est_fin    = seq_match && has_fin && (!len_nz || fits);
    assign est_need   = seq_match ? (len_nz || est_fin) : (len_nz || has_fin);
    assign rcv_est    = r_rcv_nxt + (est_accept ? {16'd0, i_item.length} : 32'd0)
                        + {31'd0, est_fin};
    assign rcv_plus1  = r_rcv_nxt + 32'd1;
    assign fw1_mid    = ack_eq_nxt ? ST_FINWAIT2 : ST_FINWAIT1;

    always_comb begin
        n_state       = r_state;
        n_peer_port   = r_peer_port;
        n_rcv_nxt     = r_rcv_nxt;
        n_snd_una     = r_snd_una;
        n_snd_nxt     = r_snd_nxt;
        n_rcv_fill    = r_rcv_fill;
        ack_due       = 1'b0;

        o_res               = '0;
        o_res.out_src_port  = i_cfg.our_port;
        o_res.out_window    = i_cfg.receive_window;

        case (kind)
            tcsm_pkg::KIND_LISTEN: begin
                n_state       = ST_LISTEN;
                n_peer_port   = 16'd0;
                n_rcv_nxt     = 32'd0;
                n_snd_una     = i_cfg.initial_seq;
                n_snd_nxt     = i_cfg.initial_seq;
                n_rcv_fill    = '0;
            end
            tcsm_pkg::KIND_SEND: begin
                if (r_state == ST_ESTAB || r_state == ST_CLOSEWAIT) begin
                    o_res.send_segment = 1'b1;
                    o_res.out_flags    = tcsm_pkg::F_ACK | tcsm_pkg::F_PSH;
                    o_res.out_seq      = r_snd_nxt;
                    o_res.out_ack      = r_rcv_nxt;
                    o_res.out_data_len = i_item.length;
                    n_snd_nxt          = r_snd_nxt + {16'd0, i_item.length};
                end else begin
                    o_res.status = 1'b1;
                end
            end
            tcsm_pkg::KIND_CLOSE: begin
                if (r_state == ST_ESTAB || r_state == ST_CLOSEWAIT) begin
                    o_res.send_segment = 1'b1;
                    o_res.out_flags    = tcsm_pkg::F_FIN | tcsm_pkg::F_ACK;
                    o_res.out_seq      = r_snd_nxt;
                    o_res.out_ack      = r_rcv_nxt;
                    n_state            = (r_state == ST_ESTAB) ? ST_FINWAIT1 : ST_LASTACK;
                    n_snd_nxt          = r_snd_nxt + 32'd1;
                end else begin
                    o_res.status = 1'b1;
                end
            end
            default: begin
                if (has_rst) begin
                    n_state = ST_CLOSED;
                end else begin
                    case (r_state)
                        ST_LISTEN: begin
                            if (has_syn && !has_ack) begin
                                n_peer_port        = i_item.peer_port;
                                n_rcv_nxt          = i_item.in_seq + 32'd1;
                                n_snd_una          = i_cfg.initial_seq;
                                n_snd_nxt          = i_cfg.initial_seq + 32'd1;
                                n_state            = ST_SYN_RCVD;
                                o_res.send_segment = 1'b1;
                                o_res.out_flags    = tcsm_pkg::F_SYN | tcsm_pkg::F_ACK;
                                o_res.out_seq      = i_cfg.initial_seq;
                                o_res.out_ack      = i_item.in_seq + 32'd1;
                            end
                        end
                        ST_SYN_RCVD: begin
                            if (ack_eq_nxt) begin
                                n_snd_una = i_item.in_ack;
                                n_state   = ST_ESTAB;
                            end
                        end
                        ST_ESTAB: begin
                            if (una_adv) begin
                                n_snd_una = i_item.in_ack;
                            end
                            if (est_accept) begin
                                n_rcv_fill = FW'(fill_sum);
                            end
                            if (est_fin) begin
                                n_state = ST_CLOSEWAIT;
                            end
                            n_rcv_nxt           = rcv_est;
                            o_res.data_accepted = est_accept;
                            ack_due             = est_need;
                        end
                        ST_CLOSEWAIT: begin
                            if (una_adv) begin
                                n_snd_una = i_item.in_ack;
                            end
                        end
                        ST_FINWAIT1: begin
                            if (ack_eq_nxt) begin
                                n_snd_una = i_item.in_ack;
                            end
                            n_state = fw1_mid;
                            if (has_fin && seq_match) begin
                                n_rcv_nxt = rcv_plus1;
                                ack_due   = 1'b1;
                                n_state   = (fw1_mid == ST_FINWAIT2) ? ST_TIMEWAIT : ST_CLOSING;
                            end
                        end
                        ST_FINWAIT2: begin
                            if (has_fin && seq_match) begin
                                n_rcv_nxt = rcv_plus1;
                                ack_due   = 1'b1;
                                n_state   = ST_TIMEWAIT;
                            end
                        end
                        ST_CLOSING: begin
                            if (ack_eq_nxt) begin
                                n_state = ST_TIMEWAIT;
                            end
                        end
                        ST_LASTACK: begin
                            if (ack_eq_nxt) begin
                                n_state = ST_CLOSED;
                            end
                        end
                        default: ;
                    endcase
                    if (ack_due) begin
                        o_res.send_segment = 1'b1;
                        o_res.out_flags    = tcsm_pkg::F_ACK;
                        o_res.out_seq      = n_snd_nxt;
                        o_res.out_ack      = n_rcv_nxt;
                    end
                end
            end
        endcase

        o_res.out_dst_port = n_peer_port;
        o_res.conn_state   = n_state;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_CLOSED;
            r_peer_port   <= 16'd0;
            r_rcv_nxt     <= 32'd0;
            r_snd_una     <= 32'd0;
            r_snd_nxt     <= 32'd0;
            r_rcv_fill    <= '0;
        end else if (i_fire) begin
            r_state       <= n_state;
            r_peer_port   <= n_peer_port;
            r_rcv_nxt     <= n_rcv_nxt;
            r_snd_una     <= n_snd_una;
            r_snd_nxt     <= n_snd_nxt;
            r_rcv_fill    <= n_rcv_fill;
        end
    end

    // fill count never passes the buffer size
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rcv_fill <= FW'(tcsm_pkg::RX_BUFFER_BYTES))
        else $error("receive fill above buffer size");

    // refused request never emits a segment
    a_refuse_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && o_res.status) |-> !o_res.send_segment)
        else $error("segment emitted on refused request");

    // accepted payload is always acknowledged with a pure ACK
    a_accept_ack: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && o_res.data_accepted) |->
        (o_res.send_segment && o_res.out_flags == tcsm_pkg::F_ACK))
        else $error("accepted data not acknowledged");

    // listen re-arms the engine with a clean receive side
    a_listen_rearm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && kind == tcsm_pkg::KIND_LISTEN) |=>
        (r_state == ST_LISTEN && r_rcv_fill == '0 && r_snd_nxt == r_snd_una))
        else $error("listen did not re-arm state");

    // without a segment the header fields stay zero
    a_idle_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && !o_res.send_segment) |->
        (o_res.out_flags == 6'd0 && o_res.out_seq == 32'd0 &&
         o_res.out_ack == 32'd0 && o_res.out_data_len == 16'd0))
        else $error("header fields set without a segment");

endmodule

[hw/rtl/tcp_connection_state_machine_unit.sv]
// TCP connection state machine unit, top level: request and result channels,
// input and result registers, config port. Depends on tcsm_pkg, tcsm_cfg_regs, tcsm_core.
//
// Usage:
//   Requests enter on i_in_valid / o_in_ready with kind, flags, seq, ack,
//   peer port and length. Each request gives exactly one result on
//   o_out_valid / i_out_ready: segment to send (flags, seq, ack, ports,
//   window, data length), data_accepted, status and the new state.
//   A request is captured in the input register; once the result register is
//   free or draining, the connection logic runs on it and writes the result
//   register, and the connection registers update in the same cycle, so
//   consecutive requests see each other's effects with no bubble. One
//   request per cycle is sustained while the receiver takes each result.
//   If the receiver stalls, the result register holds and the input register
//   still takes one more request; after that o_in_ready drops until the
//   result is taken.
//   Reset (i_rst_n low, synchronous) empties both registers, puts the
//   connection in closed with zero sequence state, and loads the config
//   registers with local port 0, initial sequence 0 and window 4096.
//   Config: APB-style, byte addresses 0x0 local port, 0x4 initial sequence,
//   0x8 receive window; write only while no request is in flight.
module tcp_connection_state_machine_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,

    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_kind,
    input  logic [5:0]  i_in_flags,
    input  logic [31:0] i_in_seq,
    input  logic [31:0] i_in_ack,
    input  logic [15:0] i_peer_port,
    input  logic [15:0] i_length,

    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_send_segment,
    output logic [5:0]  o_out_flags,
    output logic [31:0] o_out_seq,
    output logic [31:0] o_out_ack,
    output logic [15:0] o_out_src_port,
    output logic [15:0] o_out_dst_port,
    output logic [15:0] o_out_window,
    output logic [15:0] o_out_data_len,
    output logic        o_data_accepted,
    output logic        o_status,
    output logic [3:0]  o_conn_state
);

    tcsm_pkg::t_cfg    cfg;
    tcsm_pkg::t_item   r_item;
    tcsm_pkg::t_result r_res, core_res;
    logic              r_in_valid, r_out_valid;
    logic              exec;
    logic              in_take;

    tcsm_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // request moves into the core when the result register is free or draining
    assign exec       = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || exec;
    assign in_take    = i_in_valid && o_in_ready;

    tcsm_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (exec),
        .i_item  (r_item),
        .i_cfg   (cfg),
        .o_res   (core_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (exec) begin
                r_in_valid <= 1'b0;
            end
            if (exec) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_item.kind      <= i_kind;
            r_item.in_flags  <= i_in_flags;
            r_item.in_seq    <= i_in_seq;
            r_item.in_ack    <= i_in_ack;
            r_item.peer_port <= i_peer_port;
            r_item.length    <= i_length;
        end
        if (exec) begin
            r_res <= core_res;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_send_segment  = r_res.send_segment;
    assign o_out_flags     = r_res.out_flags;
    assign o_out_seq       = r_res.out_seq;
    assign o_out_ack       = r_res.out_ack;
    assign o_out_src_port  = r_res.out_src_port;
    assign o_out_dst_port  = r_res.out_dst_port;
    assign o_out_window    = r_res.out_window;
    assign o_out_data_len  = r_res.out_data_len;
    assign o_data_accepted = r_res.data_accepted;
    assign o_status        = r_res.status;
    assign o_conn_state    = r_res.conn_state;

endmodule

[verif/tcp_connection_state_machine_unit_tb.sv]
// Self-checking testbench for tcp_connection_state_machine_unit: directed and
// state-aware random requests, a connection-state predictor and a result scoreboard.
// Depends on tcsm_pkg and the tcp_connection_state_machine_unit RTL.
`timescale 1ns / 100ps

typedef enum logic [3:0] {
    ST_CLOSED    = 4'd0,
    ST_LISTEN    = 4'd1,
    ST_SYN_SENT  = 4'd2,
    ST_SYN_RCVD  = 4'd3,
    ST_ESTAB     = 4'd4,
    ST_FINWAIT1  = 4'd5,
    ST_FINWAIT2  = 4'd6,
    ST_CLOSEWAIT = 4'd7,
    ST_CLOSING   = 4'd8,
    ST_LASTACK   = 4'd9,
    ST_TIMEWAIT  = 4'd10
} t_tcp_state;

class tcp_conn_scoreboard;
    tcsm_pkg::t_cfg    cfg;
    t_tcp_state        state;
    logic [15:0]       conn_port;
    logic [31:0]       rcv_next;
    logic [31:0]       snd_unacked;
    logic [31:0]       snd_next;
    int unsigned       rx_fill;
    tcsm_pkg::t_result expected_q[$];
    int                errors;
    int                results_seen;

    function new();
        cfg.our_port       = tcsm_pkg::LOCAL_PORT_RST;
        cfg.initial_seq    = tcsm_pkg::INITIAL_SEQ_RST;
        cfg.receive_window = tcsm_pkg::RECEIVE_WINDOW_RST;
        state        = ST_CLOSED;
        conn_port    = '0;
        rcv_next     = '0;
        snd_unacked  = '0;
        snd_next     = '0;
        rx_fill      = 0;
        errors       = 0;
        results_seen = 0;
    endfunction

    function void set_reg(tcsm_pkg::t_reg_idx idx, logic [31:0] value);
        case (idx)
            tcsm_pkg::REG_LOCAL_PORT:     cfg.our_port = value[15:0];
            tcsm_pkg::REG_INITIAL_SEQ:    cfg.initial_seq = value;
            tcsm_pkg::REG_RECEIVE_WINDOW: cfg.receive_window = value[15:0];
            default: ;
        endcase
    endfunction

    // serial-number compare modulo 2^32: a is strictly ahead of b
    function bit seq_after(logic [31:0] a, logic [31:0] b);
        logic [31:0] d;
        d = a - b;
        return (d != 0) && !d[31];
    endfunction

    function void note_request(tcsm_pkg::t_item it);
        tcsm_pkg::t_result r;
        logic    has_ack;
        logic    has_fin;
        logic    ack_due;
        logic    fin_ok;
        r        = '0;
        has_ack  = (it.in_flags & tcsm_pkg::F_ACK) != 0;
        has_fin  = (it.in_flags & tcsm_pkg::F_FIN) != 0;
        ack_due  = 1'b0;
        fin_ok   = 1'b1;
        if (it.kind == tcsm_pkg::KIND_LISTEN) begin
            state       = ST_LISTEN;
            conn_port   = '0;
            rcv_next    = '0;
            snd_unacked = cfg.initial_seq;
            snd_next    = cfg.initial_seq;
            rx_fill     = 0;
        end else if (it.kind == tcsm_pkg::KIND_SEND || it.kind == tcsm_pkg::KIND_CLOSE) begin
            if (state == ST_ESTAB || state == ST_CLOSEWAIT) begin
                r.send_segment = 1'b1;
                r.out_seq      = snd_next;
                r.out_ack      = rcv_next;
                if (it.kind == tcsm_pkg::KIND_SEND) begin
                    r.out_flags    = tcsm_pkg::F_ACK | tcsm_pkg::F_PSH;
                    r.out_data_len = it.length;
                    snd_next       = snd_next + 32'(it.length);
                end else begin
                    r.out_flags = tcsm_pkg::F_FIN | tcsm_pkg::F_ACK;
                    state       = (state == ST_ESTAB) ? ST_FINWAIT1 : ST_LASTACK;
                    snd_next    = snd_next + 32'd1;
                end
            end else begin
                r.status = 1'b1;
            end
        end else if ((it.in_flags & tcsm_pkg::F_RST) != 0) begin
            state = ST_CLOSED;
        end else begin
            case (state)
                ST_LISTEN: begin
                    if ((it.in_flags & tcsm_pkg::F_SYN) != 0 && !has_ack) begin
                        conn_port      = it.peer_port;
                        rcv_next       = it.in_seq + 32'd1;
                        snd_unacked    = cfg.initial_seq;
                        snd_next       = cfg.initial_seq + 32'd1;
                        r.send_segment = 1'b1;
                        r.out_flags    = tcsm_pkg::F_SYN | tcsm_pkg::F_ACK;
                        r.out_seq      = cfg.initial_seq;
                        r.out_ack      = rcv_next;
                        state          = ST_SYN_RCVD;
                    end
                end
                ST_SYN_RCVD: begin
                    if (has_ack && it.in_ack == snd_next) begin
                        snd_unacked = it.in_ack;
                        state       = ST_ESTAB;
                    end
                end
                ST_ESTAB: begin
                    if (has_ack && seq_after(it.in_ack, snd_unacked))
                        snd_unacked = it.in_ack;
                    if (it.in_seq == rcv_next) begin
                        if (it.length != 0) begin
                            if (rx_fill + 32'(it.length) <= tcsm_pkg::RX_BUFFER_BYTES) begin
                                rx_fill         = rx_fill + 32'(it.length);
                                rcv_next        = rcv_next + 32'(it.length);
                                r.data_accepted = 1'b1;
                            end else begin
                                fin_ok = 1'b0;  // full buffer: FIN rides with the dropped data
                            end
                            ack_due = 1'b1;
                        end
                        if (has_fin && fin_ok) begin
                            rcv_next = rcv_next + 32'd1;
                            state    = ST_CLOSEWAIT;
                            ack_due  = 1'b1;
                        end
                    end else if (it.length != 0 || has_fin) begin
                        ack_due = 1'b1;
                    end
                end
                ST_CLOSEWAIT: begin
                    if (has_ack && seq_after(it.in_ack, snd_unacked))
                        snd_unacked = it.in_ack;
                end
                ST_FINWAIT1: begin
                    if (has_ack && it.in_ack == snd_next) begin
                        snd_unacked = it.in_ack;
                        state       = ST_FINWAIT2;
                    end
                    if (has_fin && it.in_seq == rcv_next) begin
                        rcv_next = rcv_next + 32'd1;
                        ack_due  = 1'b1;
                        state    = (state == ST_FINWAIT2) ? ST_TIMEWAIT : ST_CLOSING;
                    end
                end
                ST_FINWAIT2: begin
                    if (has_fin && it.in_seq == rcv_next) begin
                        rcv_next = rcv_next + 32'd1;
                        ack_due  = 1'b1;
                        state    = ST_TIMEWAIT;
                    end
                end
                ST_CLOSING: begin
                    if (has_ack && it.in_ack == snd_next)
                        state = ST_TIMEWAIT;
                end
                ST_LASTACK: begin
                    if (has_ack && it.in_ack == snd_next)
                        state = ST_CLOSED;
                end
                default: ;
            endcase
            if (ack_due) begin
                r.send_segment = 1'b1;
                r.out_flags    = tcsm_pkg::F_ACK;
                r.out_seq      = snd_next;
                r.out_ack      = rcv_next;
            end
        end
        r.out_src_port = cfg.our_port;
        r.out_dst_port = conn_port;
        r.out_window   = cfg.receive_window;
        r.conn_state   = state;
        expected_q.push_back(r);
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
        errors++;
        $display("%0t: ERROR result %0d %s: got 0x%0h, expected 0x%0h",
                 $time, results_seen, what, got, want);
    endtask

    task cmp(string field, logic [31:0] got, logic [31:0] want);
        if (got !== want)
            report(field, got, want);
    endtask

    task check_result(tcsm_pkg::t_result got);
        tcsm_pkg::t_result want;
        if (expected_q.size() == 0) begin
            report("result with no request pending", 32'(got.conn_state), 32'd0);
            return;
        end
        want = expected_q.pop_front();
        cmp("send_segment", 32'(got.send_segment), 32'(want.send_segment));
        cmp("out_flags", 32'(got.out_flags), 32'(want.out_flags));
        cmp("out_seq", got.out_seq, want.out_seq);
        cmp("out_ack", got.out_ack, want.out_ack);
        cmp("out_src_port", 32'(got.out_src_port), 32'(want.out_src_port));
        cmp("out_dst_port", 32'(got.out_dst_port), 32'(want.out_dst_port));
        cmp("out_window", 32'(got.out_window), 32'(want.out_window));
        cmp("out_data_len", 32'(got.out_data_len), 32'(want.out_data_len));
        cmp("data_accepted", 32'(got.data_accepted), 32'(want.data_accepted));
        cmp("status", 32'(got.status), 32'(want.status));
        cmp("conn_state", 32'(got.conn_state), 32'(want.conn_state));
        results_seen++;
    endtask
endclass

module tb;
    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [1:0]  i_kind;
    logic [5:0]  i_in_flags;
    logic [31:0] i_in_seq;
    logic [31:0] i_in_ack;
    logic [15:0] i_peer_port;
    logic [15:0] i_length;
    logic        o_out_valid;
    logic        i_out_ready;
    logic        o_send_segment;
    logic [5:0]  o_out_flags;
    logic [31:0] o_out_seq;
    logic [31:0] o_out_ack;
    logic [15:0] o_out_src_port;
    logic [15:0] o_out_dst_port;
    logic [15:0] o_out_window;
    logic [15:0] o_out_data_len;
    logic        o_data_accepted;
    logic        o_status;
    logic [3:0]  o_conn_state;

    int in_idle_pct   = 0;
    int out_stall_pct = 0;

    tcp_conn_scoreboard sb = new();

    tcp_connection_state_machine_unit uut (.*);

    always #5 i_clk = ~i_clk;

    always @(negedge i_clk)
        i_out_ready <= ($urandom_range(99) >= out_stall_pct);

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            sb.check_result({o_send_segment, o_out_flags, o_out_seq, o_out_ack,
                             o_out_src_port, o_out_dst_port, o_out_window,
                             o_out_data_len, o_data_accepted, o_status, o_conn_state});
    end

    function automatic tcsm_pkg::t_item mk(logic [1:0] kind, logic [5:0] flags,
                                           logic [31:0] seq, logic [31:0] ack,
                                           logic [15:0] port, logic [15:0] len);
        tcsm_pkg::t_item it;
        it.kind      = kind;
        it.in_flags  = flags;
        it.in_seq    = seq;
        it.in_ack    = ack;
        it.peer_port = port;
        it.length    = len;
        return it;
    endfunction

    // Mostly well-formed traffic for the current predicted state, some broken
    // variants, some RSTs and some fully random requests.
    function automatic tcsm_pkg::t_item gen_request();
        tcsm_pkg::t_item it;
        int unsigned     r;
        logic            bad;
        r   = $urandom_range(99);
        bad = ($urandom_range(9) == 0);
        it  = mk(tcsm_pkg::KIND_SEGMENT, tcsm_pkg::F_ACK, sb.rcv_next, sb.snd_next,
                 16'($urandom), 16'd0);
        if (r < 8) begin
            it = mk(2'($urandom), 6'($urandom), $urandom, $urandom, 16'($urandom),
                    16'($urandom));
            return it;
        end
        if (r < 11) begin
            it.in_flags = tcsm_pkg::F_RST | 6'($urandom);
            return it;
        end
        case (sb.state)
            ST_LISTEN: begin
                it.in_flags = (6'($urandom) & ~(tcsm_pkg::F_RST | tcsm_pkg::F_ACK))
                              | tcsm_pkg::F_SYN;
                it.in_seq   = $urandom;
                if (bad)
                    it.in_flags = it.in_flags | tcsm_pkg::F_ACK;
            end
            ST_SYN_RCVD: begin
                if (bad)
                    it.in_ack = sb.snd_next - $urandom_range(1, 3);
            end
            ST_ESTAB, ST_CLOSEWAIT: begin
                if (r < 35) begin
                    it.kind   = tcsm_pkg::KIND_SEND;
                    it.length = ($urandom_range(19) == 0) ? 16'($urandom)
                                                          : 16'($urandom_range(1460));
                end else if (r < 40) begin
                    it.kind = tcsm_pkg::KIND_CLOSE;
                end else begin
                    it.in_ack = sb.snd_unacked + $urandom_range(sb.snd_next - sb.snd_unacked);
                    if (bad)
                        it.in_ack = $urandom;
                    it.length = ($urandom_range(19) == 0) ? 16'($urandom)
                                                          : 16'($urandom_range(300));
                    if ($urandom_range(9) == 0)
                        it.in_flags = it.in_flags | tcsm_pkg::F_FIN;
                    if ($urandom_range(1) == 1)
                        it.in_flags = it.in_flags | tcsm_pkg::F_PSH;
                    if ($urandom_range(7) == 0)
                        it.in_seq = sb.rcv_next + $urandom_range(1, 2000);
                end
            end
            ST_FINWAIT1: begin
                case (r % 3)
                    0:       it.in_flags = tcsm_pkg::F_ACK;
                    1:       it.in_flags = tcsm_pkg::F_FIN;
                    default: it.in_flags = tcsm_pkg::F_FIN | tcsm_pkg::F_ACK;
                endcase
                if (bad) begin
                    it.in_seq = sb.rcv_next + 32'd1;
                    it.in_ack = sb.snd_next - 32'd1;
                end
            end
            ST_FINWAIT2: begin
                it.in_flags = tcsm_pkg::F_FIN | tcsm_pkg::F_ACK;
                if (bad)
                    it.in_seq = sb.rcv_next - 32'd1;
            end
            ST_CLOSING, ST_LASTACK: begin
                if (bad)
                    it.in_ack = sb.snd_next + 32'd1;
            end
            default: begin
                if (r < 80) begin
                    it.kind = tcsm_pkg::KIND_LISTEN;
                end else begin
                    it.kind     = 2'($urandom_range(2));
                    it.in_flags = 6'($urandom) & ~tcsm_pkg::F_RST;
                    it.length   = 16'($urandom_range(100));
                end
            end
        endcase
        return it;
    endfunction

    task push_request(tcsm_pkg::t_item it);
        @(negedge i_clk);
        while ($urandom_range(99) < in_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_kind      <= it.kind;
        i_in_flags  <= it.in_flags;
        i_in_seq    <= it.in_seq;
        i_in_ack    <= it.in_ack;
        i_peer_port <= it.peer_port;
        i_length    <= it.length;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_request(it);
    endtask

    // stop sending and wait for every outstanding result
    task settle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (sb.expected_q.size() != 0)
            @(posedge i_clk);
    endtask

    task write_reg(tcsm_pkg::t_reg_idx idx, logic [31:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        sb.set_reg(idx, value);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task run_directed();
        push_request(mk(tcsm_pkg::KIND_SEND, 6'h3F, '1, '1, 16'hFFFF, 16'hFFFF));  // refused
        push_request(mk(tcsm_pkg::KIND_CLOSE, 6'h00, '0, '0, 16'h0000, 16'h0000)); // refused
        push_request(mk(tcsm_pkg::KIND_SEGMENT, tcsm_pkg::F_SYN, '0, '0, 16'h1234, 16'h0000));
        push_request(mk(tcsm_pkg::KIND_LISTEN, 6'h3F, '1, '1, 16'hFFFF, 16'hFFFF));
        push_request(mk(tcsm_pkg::KIND_SEGMENT, tcsm_pkg::F_SYN | tcsm_pkg::F_ACK, 32'd5, '0,
                        16'd1, 16'd0));
        push_request(mk(tcsm_pkg::KIND_SEND, 6'h00, '0, '0, 16'h0000, 16'd10));
        // SYN at the top of sequence space: rcv_next wraps to zero
        push_request(mk(tcsm_pkg::KIND_SEGMENT, tcsm_pkg::F_SYN | tcsm_pkg::F_PSH, '1, '0,
                        16'hFFFF, 16'd0));
        push_request(mk(tcsm_pkg::KIND_SEGMENT, tcsm_pkg::F_ACK, sb.rcv_next,
                        sb.snd_next + 32'd1, 16'd0, 16'd0));
        push_request(mk(tcsm_pkg::KIND_CLOSE, 6'h00, '0, '0, 16'h0000, 16'h0000));
        push_request(mk(tcsm_pkg::KIND_SEGMENT, tcsm_pkg::F_ACK, sb.rcv_next, sb.snd_next,
                        16'd0, 16'd0));
        push_request(mk(tcsm_pkg::KIND_SEGMENT, tcsm_pkg::F_ACK | tcsm_pkg::F_PSH,
                        sb.rcv_next, sb.snd_next, 16'd0, 16'd100));
        push_request(mk(tcsm_pkg::KIND_SEGMENT, tcsm_pkg::F_ACK, sb.rcv_next + 32'd5,
                        sb.snd_next, 16'd0, 16'd10));
        push_request(mk(tcsm_pkg::KIND_SEND, 6'h00, '0, '0, 16'h0000, 16'hFFFF));
        push_request(mk(tcsm_pkg::KIND_SEND, 6'h00, '0, '0, 16'h0000, 16'h0000));
        push_request(mk(tcsm_pkg::KIND_SEGMENT, tcsm_pkg::F_ACK | 6'h20, sb.rcv_next,
                        sb.snd_next, 16'd0, 16'd0));
        // does not fit in the receive buffer: dropped, FIN not taken
        push_request(mk(tcsm_pkg::KIND_SEGMENT, tcsm_pkg::F_ACK | tcsm_pkg::F_FIN,
                        sb.rcv_next, sb.snd_next, 16'd0, 16'd4096));
        push_request(mk(tcsm_pkg::KIND_SEGMENT, tcsm_pkg::F_ACK | tcsm_pkg::F_FIN,
                        sb.rcv_next, sb.snd_next, 16'd0, 16'd0));
        push_request(mk(tcsm_pkg::KIND_SEND, 6'h00, '0, '0, 16'h0000, 16'h8000));
        push_request(mk(tcsm_pkg::KIND_CLOSE, 6'h00, '0, '0, 16'h0000, 16'h0000));
        push_request(mk(tcsm_pkg::KIND_SEGMENT, tcsm_pkg::F_ACK, '0, sb.snd_next - 32'd1,
                        16'd0, 16'd0));
        push_request(mk(tcsm_pkg::KIND_SEGMENT, tcsm_pkg::F_ACK, '0, sb.snd_next,
                        16'd0, 16'd0));
        // second session: simultaneous close through closing and timewait
        push_request(mk(tcsm_pkg::KIND_LISTEN, 6'h00, '0, '0, 16'h0000, 16'h0000));
        push_request(mk(tcsm_pkg::KIND_SEGMENT, tcsm_pkg::F_SYN, 32'h7FFF_FFFF, '0,
                        16'h8001, 16'd0));
        push_request(mk(tcsm_pkg::KIND_SEGMENT, tcsm_pkg::F_ACK, sb.rcv_next, sb.snd_next,
                        16'd0, 16'd0));
        push_request(mk(tcsm_pkg::KIND_CLOSE, 6'h00, '0, '0, 16'h0000, 16'h0000));
        push_request(mk(tcsm_pkg::KIND_SEGMENT, tcsm_pkg::F_FIN, sb.rcv_next, '0,
                        16'd0, 16'd0));
        push_request(mk(tcsm_pkg::KIND_SEGMENT, tcsm_pkg::F_ACK, sb.rcv_next, sb.snd_next,
                        16'd0, 16'd0));
        push_request(mk(tcsm_pkg::KIND_SEGMENT, tcsm_pkg::F_RST, '0, '0, 16'd0, 16'd0));
    endtask

    initial begin
        int          ph;
        int          n;
        logic [31:0] lport;
        logic [31:0] iss;
        logic [31:0] rwin;
        i_rst_n     = 1'b0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        i_in_valid  = 1'b0;
        i_kind      = tcsm_pkg::KIND_SEGMENT;
        i_in_flags  = '0;
        i_in_seq    = '0;
        i_in_ack    = '0;
        i_peer_port = '0;
        i_length    = '0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        run_directed();

        for (ph = 0; ph < 5; ph++) begin
            settle();
            case (ph)
                0: begin
                    lport = 32'hFFFF; iss = '1; rwin = 32'h0;
                    in_idle_pct = 0; out_stall_pct = 0;
                end
                1: begin
                    lport = 32'h0; iss = 32'hFFFF_FF00; rwin = 32'hFFFF;
                    in_idle_pct = 73; out_stall_pct = 0;
                end
                2: begin
                    lport = $urandom; iss = $urandom; rwin = $urandom;
                    in_idle_pct = 0; out_stall_pct = 73;
                end
                3: begin
                    lport = $urandom; iss = 32'h7FFF_FFF0;
                    rwin = 32'(tcsm_pkg::RECEIVE_WINDOW_RST);
                    in_idle_pct = 32; out_stall_pct = 32;
                end
                default: begin
                    lport = $urandom; iss = 32'h0; rwin = $urandom;
                    in_idle_pct = 0; out_stall_pct = 0;
                end
            endcase
            write_reg(tcsm_pkg::REG_LOCAL_PORT, lport & 32'hFFFF);
            write_reg(tcsm_pkg::REG_INITIAL_SEQ, iss);
            write_reg(tcsm_pkg::REG_RECEIVE_WINDOW, rwin & 32'hFFFF);
            for (n = 0; n < 240; n++) begin
                if (ph == 2 && n == 120)
                    settle();  // hold off until the pipeline has drained
                push_request(gen_request());
            end
        end

        settle();
        repeat (8) @(posedge i_clk);
        if (sb.expected_q.size() != 0)
            sb.report("results never seen", 32'(sb.expected_q.size()), 32'd0);
        if (sb.errors == 0)
            $display("tcp_connection_state_machine_unit: match");
        else
            $display("tcp_connection_state_machine_unit: mismatch");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("tcp_connection_state_machine_unit: mismatch");
        $finish;
    end
endmodule

[tcp_connection_state_machine_unit.f]
hw/rtl/tcsm_pkg.sv
hw/rtl/tcsm_cfg_regs.sv
hw/rtl/tcsm_core.sv
hw/rtl/tcp_connection_state_machine_unit.sv
verif/tcp_connection_state_machine_unit_tb.sv
